// ----- hw/rtl/tsr_pkg.sv -----
// Shared types and constants for the timestamp rescaler.
package tsr_pkg;

	localparam logic [63:0] STAMP_ERROR = 64'h8000_0000_0000_0000;
	localparam logic [30:0] SCALE_RESET = 31'd1000000;

	typedef enum logic [1:0] {
		RND_FLOOR = 2'd0,
		RND_CEIL  = 2'd1,
		RND_NEAR  = 2'd2,
		RND_ZERO  = 2'd3
	} round_mode_t;

	// item state carried along a divider chain
	typedef struct packed {
		logic        valid;
		logic        neg;
		round_mode_t mode;
		logic [63:0] q;
		logic [30:0] rem;
		logic [63:0] word;
	} tsr_cell_t;

endpackage

// ----- hw/rtl/timestamp_timescale_rescaler_unit.sv -----
// Top level of the timestamp rescaler: input stage, two divider chains, multiply and output.
//
// channel  | dir | handshake             | contents
// s_axis   | in  | tvalid/tready         | tdata: stamp_in[63:0], round_mode[65:64], pad
// m_axis   | out | tvalid/tready         | tdata: stamp_out[63:0]; tuser: conv_error
// cfg      | in  | cfg_we                | cfg_index 0 scale_from, 1 scale_to; cfg_data
//
// One item per cycle while the output is not stalled; 101 register stages (64 cells for M/A,
// 32 cells for the fraction, plus input, fraction product, two multiply stages and the output
// register).
// Reset clears the valid bits and loads both scales with 1000000.
// A stalled output holds the whole pipeline; s_axis_tready is low only then.
module timestamp_timescale_rescaler_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,   // stamp_in[63:0], round_mode[65:64]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // stamp_out[63:0]
	output logic        m_axis_tuser,   // conv_error
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [30:0] cfg_data
);

	logic        en;
	logic [30:0] scale_from_q;
	logic [30:0] scale_to_q;
	logic        scale_zero;

	logic [63:0]          stamp;
	tsr_pkg::round_mode_t mode_in;
	tsr_pkg::tsr_cell_t   ent;
	tsr_pkg::tsr_cell_t   st_s1;
	tsr_pkg::tsr_cell_t   c1;
	tsr_pkg::tsr_cell_t   st_s2;
	tsr_pkg::tsr_cell_t   c2;
	logic [30:0]          rnd;
	logic [62:0]          prod;

	logic        valid_s3;
	logic        neg_s3;
	logic [62:0] pl_s3;
	logic [62:0] ph_s3;
	logic [31:0] e_s3;
	logic [95:0] sum;
	logic        valid_s4;
	logic        neg_s4;
	logic        ovf_s4;
	logic [63:0] res_s4;
	logic        out_valid_q;
	logic [63:0] out_data_q;
	logic        out_err_q;
	logic        out_neg_q;

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;
	assign scale_zero    = (scale_from_q == '0) || (scale_to_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_from_q <= tsr_pkg::SCALE_RESET;
			scale_to_q   <= tsr_pkg::SCALE_RESET;
		end else if (cfg_we) begin
			if (cfg_index) begin
				scale_to_q <= cfg_data;
			end else begin
				scale_from_q <= cfg_data;
			end
		end
	end

	// magnitude and mirrored rounding for negative stamps
	always_comb begin
		stamp   = s_axis_tdata[63:0];
		mode_in = tsr_pkg::round_mode_t'(s_axis_tdata[65:64]);
		ent       = '0;
		ent.valid = s_axis_tvalid;
		ent.neg   = stamp[63];
		ent.word  = stamp[63] ? (~stamp + 64'd1) : stamp;
		ent.mode  = mode_in;
		if (stamp[63]) begin
			case (mode_in)
				tsr_pkg::RND_FLOOR: ent.mode = tsr_pkg::RND_CEIL;
				tsr_pkg::RND_CEIL:  ent.mode = tsr_pkg::RND_FLOOR;
				default:            ent.mode = mode_in;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1 <= '0;
		end else if (en) begin
			st_s1 <= ent;
		end
	end

	tsr_div_chain #(.STEPS(64)) u_quot (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.divisor (scale_from_q),
		.src     (st_s1),
		.dst     (c1)
	);

	// r*B + c; top 31 bits are below A, so they seed the fraction divider
	always_comb begin
		case (c1.mode)
			tsr_pkg::RND_NEAR: rnd = {1'b0, scale_from_q[30:1]};
			tsr_pkg::RND_CEIL: rnd = scale_from_q - 31'd1;
			default:           rnd = '0;
		endcase
		prod = {1'b0, {31'b0, c1.rem} * {31'b0, scale_to_q}} + {32'b0, rnd};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s2 <= '0;
		end else if (en) begin
			st_s2.valid <= c1.valid;
			st_s2.neg   <= c1.neg;
			st_s2.mode  <= c1.mode;
			st_s2.q     <= c1.word;
			st_s2.rem   <= prod[62:32];
			st_s2.word  <= {prod[31:0], 32'b0};
		end
	end

	tsr_div_chain #(.STEPS(32)) u_frac (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.divisor (scale_from_q),
		.src     (st_s2),
		.dst     (c2)
	);

	// q*B split in two partial products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s3 <= c2.valid;
			valid_s4 <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	assign sum = {1'b0, ph_s3, 32'b0} + {33'b0, pl_s3} + {64'b0, e_s3};

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s3 <= c2.neg;
			pl_s3  <= {31'b0, c2.q[31:0]} * {32'b0, scale_to_q};
			ph_s3  <= {31'b0, c2.q[63:32]} * {32'b0, scale_to_q};
			e_s3   <= c2.word[31:0];
			neg_s4 <= neg_s3;
			res_s4 <= sum[63:0];
			ovf_s4 <= (|sum[95:63]) || scale_zero;
			out_neg_q  <= neg_s4;
			out_err_q  <= ovf_s4;
			out_data_q <= ovf_s4 ? tsr_pkg::STAMP_ERROR
				: (neg_s4 ? (~res_s4 + 64'd1) : res_s4);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_err_q;

`ifndef SYNTHESIS
	a_err_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_err_q |-> out_data_q == tsr_pkg::STAMP_ERROR)
		else $error("error item with wrong stamp value");
	a_zero_scale: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && scale_zero |-> out_err_q)
		else $error("zero scale not flagged");
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_err_q && !out_neg_q |-> !out_data_q[63])
		else $error("positive stamp gave negative result");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |=> out_valid_q && $stable(out_data_q))
		else $error("stalled result lost");
`endif

endmodule

// ----- hw/rtl/tsr_div_cell.sv -----
// One restoring-division cell: one quotient bit per cycle while en is high.
module tsr_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [30:0]       divisor,
	input  tsr_pkg::tsr_cell_t src,
	output tsr_pkg::tsr_cell_t dst
);

	logic [31:0]        part;
	logic [32:0]        diff;
	logic               fit;
	tsr_pkg::tsr_cell_t res;
	logic               valid_q;
	tsr_pkg::tsr_cell_t data_q;

	always_comb begin
		part = {src.rem, src.word[63]};
		diff = {1'b0, part} - {2'b0, divisor};
		fit  = !diff[32];
		res      = src;
		res.word = {src.word[62:0], fit};
		res.rem  = fit ? diff[30:0] : part[30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= src.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= res;
		end
	end

	always_comb begin
		dst       = data_q;
		dst.valid = valid_q;
	end

endmodule

// ----- hw/rtl/tsr_div_chain.sv -----
// Row of division cells, one quotient bit per cell.
module tsr_div_chain #(
	parameter int STEPS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [30:0]       divisor,
	input  tsr_pkg::tsr_cell_t src,
	output tsr_pkg::tsr_cell_t dst
);

	tsr_pkg::tsr_cell_t link [STEPS+1];

	assign link[0] = src;

	for (genvar i = 0; i < STEPS; i++) begin : g_cell
		tsr_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.divisor (divisor),
			.src     (link[i]),
			.dst     (link[i+1])
		);
	end

	assign dst = link[STEPS];

endmodule

// ----- tb/tsr_checker.sv -----
// Checker for the timestamp rescaler: predicts each result and compares it at the output.
module tsr_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata,
	input  logic        m_axis_tuser,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [30:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [63:0] stamp;
		logic        err;
	} stamp_result_t;

	logic [30:0] from_q, to_q;
	stamp_result_t expected_q[$];
	int mismatches;

	assign fail_count = mismatches;
	assign pending = expected_q.size();

	function automatic stamp_result_t rescale(logic [63:0] stamp,
			tsr_pkg::round_mode_t mode_in, logic [30:0] sa, logic [30:0] sb);
		stamp_result_t res;
		tsr_pkg::round_mode_t mode;
		logic [63:0] a, b, mag, q, r, c, e;
		logic neg;
		a = {33'd0, sa};
		b = {33'd0, sb};
		mode = mode_in;
		c = '0;
		res = '{stamp: tsr_pkg::STAMP_ERROR, err: 1'b1};
		if (sa == '0 || sb == '0)
			return res;
		neg = stamp[63];
		mag = neg ? (~stamp + 64'd1) : stamp;
		if (neg && mode == tsr_pkg::RND_FLOOR)
			mode = tsr_pkg::RND_CEIL;
		else if (neg && mode == tsr_pkg::RND_CEIL)
			mode = tsr_pkg::RND_FLOOR;
		if (mode == tsr_pkg::RND_NEAR)
			c = a >> 1;
		else if (mode == tsr_pkg::RND_CEIL)
			c = a - 64'd1;
		q = mag / a;
		r = mag % a;
		e = (r * b + c) / a;
		if (!(q < 64'd2147483647 || q <= (64'h7FFF_FFFF_FFFF_FFFF - e) / b))
			return res;
		res.stamp = q * b + e;
		if (neg)
			res.stamp = ~res.stamp + 64'd1;
		res.err = 1'b0;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stamp_result_t want;
		if (!arst_n) begin
			from_q <= tsr_pkg::SCALE_RESET;
			to_q <= tsr_pkg::SCALE_RESET;
			mismatches = 0;
			expected_q.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_q.push_back(rescale(s_axis_tdata[63:0],
					tsr_pkg::round_mode_t'(s_axis_tdata[65:64]), from_q, to_q));
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected item: stamp %h err %b", m_axis_tdata, m_axis_tuser);
				end else begin
					want = expected_q.pop_front();
					if (want.stamp !== m_axis_tdata || want.err !== m_axis_tuser) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %h/%b got %h/%b",
								want.stamp, want.err, m_axis_tdata, m_axis_tuser);
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == 1'b0)
					from_q <= cfg_data;
				else
					to_q <= cfg_data;
			end
		end
	end
endmodule

// ----- tb/testbench.sv -----
// Testbench top for the timestamp rescaler: stimulus, configuration phases and verdict.
module testbench;

	localparam int LATENCY = 101;
	localparam int WATCHDOG = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [30:0] cfg_data = '0;
	int          fail_count, pending;
	int          quiet_cycles = 0;
	bit          calm = 1'b0;
	int          sink_gap = 0;

	always #1 clk = ~clk;

	timestamp_timescale_rescaler_unit u_dut (.*);

	tsr_checker u_chk (.*);

	// output side: random stall bursts, none at the end
	always @(posedge clk) begin
		if (calm) begin
			m_axis_tready <= 1'b1;
		end else if (sink_gap > 0) begin
			sink_gap <= sink_gap - 1;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			sink_gap <= $urandom_range(1, 17) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_item(logic [63:0] stamp, tsr_pkg::round_mode_t mode);
		int gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 17);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, mode, stamp};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [30:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand_stamp();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: v = v >> $urandom_range(1, 63);
			1: v = -(v >> $urandom_range(1, 63));
			2: v = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 63'd0} + 64'($urandom_range(0, 3));
			3: v = $urandom_range(0, 1)
				? 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3))
				: 64'd0 - 64'($urandom_range(0, 3));
			default: ;
		endcase
		return v;
	endfunction

	function automatic logic [30:0] rand_scale();
		case ($urandom_range(0, 5))
			0: return 31'h7FFF_FFFF - 31'($urandom_range(0, 2));
			1: return 31'($urandom_range(1, 3));
			2: return 31'($urandom_range(1, 100000));
			3: return 31'd90000;
			default: return 31'($urandom);
		endcase
	endfunction

	initial begin
		logic [63:0] dir_stamps[8];
		logic [30:0] from_v, to_v;
		dir_stamps = '{64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
			64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001, 64'd1500000, -64'd1500001};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset scales, then rate change to the max scale, then zero scales
		for (int i = 0; i < 8; i++)
			send_item(dir_stamps[i], tsr_pkg::round_mode_t'(i % 4));
		drain();
		write_reg(1'b0, 31'd3);
		write_reg(1'b1, 31'h7FFF_FFFF);
		for (int i = 0; i < 8; i++)
			send_item(dir_stamps[i], tsr_pkg::round_mode_t'((i + 1) % 4));
		drain();
		write_reg(1'b0, 31'd0);
		send_item(64'd5, tsr_pkg::RND_NEAR);
		drain();
		write_reg(1'b0, 31'd7);
		write_reg(1'b1, 31'd0);
		send_item(64'd5, tsr_pkg::RND_ZERO);
		drain();
		for (int ph = 0; ph < 12; ph++) begin
			from_v = rand_scale();
			to_v = rand_scale();
			write_reg(1'b0, from_v);
			write_reg(1'b1, to_v);
			if (ph == 11)
				calm = 1'b1;
			for (int k = 0; k < 100; k++)
				send_item(rand_stamp(), tsr_pkg::round_mode_t'($urandom_range(0, 3)));
			drain();
		end
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// ----- filelist.f -----
hw/rtl/tsr_pkg.sv
hw/rtl/tsr_div_cell.sv
hw/rtl/tsr_div_chain.sv
hw/rtl/timestamp_timescale_rescaler_unit.sv
tb/tsr_checker.sv
tb/testbench.sv
